@@ design/tsdt_pkg.sv @@
`timescale 1ns / 1ps
// types and constants shared by the thermometer scratchpad decoder
package tsdt_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned CelW   = 17;
  localparam int unsigned FahW   = 21;
  localparam int unsigned AddrW  = 4;
  localparam int unsigned DataW  = 32;

  localparam logic [ByteW-1:0] FAM_NINE     = 8'h10;
  localparam logic [ByteW-1:0] FAM_TWELVE_A = 8'h28;
  localparam logic [ByteW-1:0] FAM_TWELVE_B = 8'h22;
  localparam logic [ByteW-1:0] FAM_THIRTEEN = 8'h26;

  localparam logic [ByteW-1:0] COUNT_PER_C  = 8'h10;
  localparam logic [15:0]      REMAIN_BIAS  = 16'd12;
  localparam logic signed [FahW-1:0] FAH_OFFSET = 21'sd5120;

  // resolution field, bits 6:5 of byte 4
  typedef enum logic [1:0] {
    RES_9  = 2'b00,
    RES_10 = 2'b01,
    RES_11 = 2'b10,
    RES_12 = 2'b11
  } res_e;

  typedef enum logic [1:0] {
    REG_FAMILY_CODE   = 2'd0,
    REG_REPORT_LOW    = 2'd1,
    REG_REPORT_HIGH   = 2'd2,
    REG_TRIGGER_LEVEL = 2'd3
  } reg_idx_e;

  localparam logic [ByteW-1:0]       RST_FAMILY  = 8'h28;
  localparam logic signed [FahW-1:0] RST_LOW     = 21'sd9600;
  localparam logic signed [FahW-1:0] RST_HIGH    = 21'sd16000;
  localparam logic signed [FahW-1:0] RST_TRIGGER = 21'sd12800;
  localparam logic signed [CelW-1:0] RST_CEL     = 17'sd640;
  localparam logic signed [FahW-1:0] RST_FAH     = 21'sd10880;

  typedef struct packed {
    logic [ByteW-1:0]       family_code;
    logic signed [FahW-1:0] report_low;
    logic signed [FahW-1:0] report_high;
    logic signed [FahW-1:0] trigger_level;
  } cfg_t;

  typedef struct packed {
    logic [ByteW-1:0] pad_byte0;
    logic [ByteW-1:0] pad_byte1;
    logic [ByteW-1:0] pad_byte2;
    logic [ByteW-1:0] pad_byte4;
    logic [ByteW-1:0] pad_byte6;
    logic [ByteW-1:0] pad_byte7;
  } pad_t;

  typedef struct packed {
    logic                   known;
    logic signed [CelW-1:0] celsius;
  } dec_t;

endpackage

@@ design/tsdt_if.sv @@
`timescale 1ns / 1ps
// valid/ready channel interfaces for scratchpad words and result words
interface tsdt_in_if;
  import tsdt_pkg::*;

  logic             valid;
  logic             ready;
  logic [ByteW-1:0] pad_byte0;
  logic [ByteW-1:0] pad_byte1;
  logic [ByteW-1:0] pad_byte2;
  logic [ByteW-1:0] pad_byte4;
  logic [ByteW-1:0] pad_byte6;
  logic [ByteW-1:0] pad_byte7;

  modport source (output valid, pad_byte0, pad_byte1, pad_byte2, pad_byte4,
                  pad_byte6, pad_byte7, input ready);
  modport sink (input valid, pad_byte0, pad_byte1, pad_byte2, pad_byte4,
                pad_byte6, pad_byte7, output ready);
endinterface

interface tsdt_out_if;
  import tsdt_pkg::*;

  logic                   valid;
  logic                   ready;
  logic signed [CelW-1:0] celsius_32nds;
  logic signed [FahW-1:0] fahrenheit_160ths;
  logic                   reading_accepted;
  logic                   family_unknown;
  logic                   crossing_event;
  logic                   at_or_above;

  modport source (output valid, celsius_32nds, fahrenheit_160ths, reading_accepted,
                  family_unknown, crossing_event, at_or_above, input ready);
  modport sink (input valid, celsius_32nds, fahrenheit_160ths, reading_accepted,
                family_unknown, crossing_event, at_or_above, output ready);
endinterface

@@ design/tsdt_cfg_regs.sv @@
`timescale 1ns / 1ps
// apb configuration registers: family code, report window and trigger level
module tsdt_cfg_regs (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [tsdt_pkg::AddrW-1:0] paddr,
  input  logic [tsdt_pkg::DataW-1:0] pwdata,
  output logic [tsdt_pkg::DataW-1:0] prdata,
  output logic                      pready,
  output tsdt_pkg::cfg_t            cfg_o
);
  import tsdt_pkg::*;

  cfg_t     cfg_q, cfg_d;
  reg_idx_e idx;
  logic     wr_en;

  assign pready = 1'b1;
  assign idx    = reg_idx_e'(paddr[AddrW-1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        REG_FAMILY_CODE:   cfg_d.family_code   = pwdata[ByteW-1:0];
        REG_REPORT_LOW:    cfg_d.report_low    = pwdata[FahW-1:0];
        REG_REPORT_HIGH:   cfg_d.report_high   = pwdata[FahW-1:0];
        REG_TRIGGER_LEVEL: cfg_d.trigger_level = pwdata[FahW-1:0];
        default:           cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_FAMILY_CODE:   prdata = {{(DataW-ByteW){1'b0}}, cfg_q.family_code};
      REG_REPORT_LOW:    prdata = {{(DataW-FahW){cfg_q.report_low[FahW-1]}},
                                   cfg_q.report_low};
      REG_REPORT_HIGH:   prdata = {{(DataW-FahW){cfg_q.report_high[FahW-1]}},
                                   cfg_q.report_high};
      REG_TRIGGER_LEVEL: prdata = {{(DataW-FahW){cfg_q.trigger_level[FahW-1]}},
                                   cfg_q.trigger_level};
      default:           prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.family_code   <= RST_FAMILY;
      cfg_q.report_low    <= RST_LOW;
      cfg_q.report_high   <= RST_HIGH;
      cfg_q.trigger_level <= RST_TRIGGER;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

@@ design/tsdt_decode.sv @@
`timescale 1ns / 1ps
// scratchpad decode by sensor family into celsius 1/32 degree
module tsdt_decode (
  input  logic [tsdt_pkg::ByteW-1:0] family_i,
  input  tsdt_pkg::pad_t             pad_i,
  output tsdt_pkg::dec_t             dec_o
);
  import tsdt_pkg::*;

  logic [15:0] word;
  logic [15:0] raw9;
  logic [15:0] raw9_fine;
  logic [15:0] raw12;
  logic [12:0] raw13;
  res_e        res;

  assign word = {pad_i.pad_byte1, pad_i.pad_byte0};
  assign raw9 = {word[12:0], 3'b000};
  assign raw9_fine = {raw9[15:4], 4'b0000} + REMAIN_BIAS - {8'h00, pad_i.pad_byte6};
  assign res  = res_e'(pad_i.pad_byte4[6:5]);
  assign raw13 = {pad_i.pad_byte2, pad_i.pad_byte1[7:3]};

  always_comb begin
    case (res)
      RES_9:   raw12 = {word[15:3], 3'b000};
      RES_10:  raw12 = {word[15:2], 2'b00};
      RES_11:  raw12 = {word[15:1], 1'b0};
      RES_12:  raw12 = word;
      default: raw12 = word;
    endcase
  end

  always_comb begin
    dec_o.known   = 1'b1;
    dec_o.celsius = '0;
    if (family_i == FAM_NINE) begin
      if (pad_i.pad_byte7 == COUNT_PER_C) begin
        dec_o.celsius = {raw9_fine, 1'b0};
      end else begin
        dec_o.celsius = {raw9, 1'b0};
      end
    end else if (family_i == FAM_TWELVE_A || family_i == FAM_TWELVE_B) begin
      dec_o.celsius = {raw12, 1'b0};
    end else if (family_i == FAM_THIRTEEN) begin
      dec_o.celsius = {{(CelW-13){raw13[12]}}, raw13};
    end else begin
      dec_o.known = 1'b0;
    end
  end

endmodule

@@ design/temp_scratchpad_decode_threshold.sv @@
`timescale 1ns / 1ps
// top level: thermometer scratchpad decoder with report window and trigger events
//
// in_i carries one scratchpad read per word (bytes 0, 1, 2, 4, 6, 7). each word is
// decoded by the family selected in the family_code register, converted to
// fahrenheit (c*9 + 5120, 1/160 degree) and stored when it lies inside the report
// window. out_o returns one word per input word: the stored temperatures, the
// accept and unknown-family flags, and the trigger crossing event and side.
// an input handshake reaches the result handshake through the input register and then
// the result register, with the decode and compare logic between them. one word is
// taken per cycle while out_o does not stall; the stored reading is updated in
// the same cycle the result register loads, so each word sees its predecessor's state.
// when out_o stalls the result register holds, the input register fills and
// in_i.ready drops; a new word is taken as soon as the result moves on.
// reset restores the register defaults, a stored reading of 20 c / 68 f with the
// trigger side set to below, and empties both registers.
// the apb port writes registers at 4*index; reads sign extend all but family_code.
module temp_scratchpad_decode_threshold (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [tsdt_pkg::AddrW-1:0] paddr,
  input  logic [tsdt_pkg::DataW-1:0] pwdata,
  output logic [tsdt_pkg::DataW-1:0] prdata,
  output logic                       pready,
  tsdt_in_if.sink                    in_i,
  tsdt_out_if.source                 out_o
);
  import tsdt_pkg::*;

  cfg_t cfg;
  dec_t dec;

  logic in_valid_q;
  pad_t pad_q;
  logic adv;

  logic signed [CelW-1:0] kept_cel_q, kept_cel_d;
  logic signed [FahW-1:0] kept_fah_q, kept_fah_d;
  logic                   below_q, below_d;
  logic signed [FahW-1:0] fah;
  logic                   in_window;
  logic                   take;
  logic                   at_or_above;
  logic                   event_w;

  logic                   out_valid_q;
  logic signed [CelW-1:0] out_cel_q;
  logic signed [FahW-1:0] out_fah_q;
  logic                   out_acc_q;
  logic                   out_unk_q;
  logic                   out_evt_q;
  logic                   out_ge_q;

  tsdt_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  tsdt_decode u_decode (
    .family_i (cfg.family_code),
    .pad_i    (pad_q),
    .dec_o    (dec)
  );

  assign adv        = in_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !in_valid_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      pad_q.pad_byte0 <= in_i.pad_byte0;
      pad_q.pad_byte1 <= in_i.pad_byte1;
      pad_q.pad_byte2 <= in_i.pad_byte2;
      pad_q.pad_byte4 <= in_i.pad_byte4;
      pad_q.pad_byte6 <= in_i.pad_byte6;
      pad_q.pad_byte7 <= in_i.pad_byte7;
    end
  end

  // f = c*9 + 5120
  assign fah = ({{(FahW-CelW){dec.celsius[CelW-1]}}, dec.celsius} <<< 3)
             + {{(FahW-CelW){dec.celsius[CelW-1]}}, dec.celsius} + FAH_OFFSET;
  assign in_window = (fah >= cfg.report_low) && (fah <= cfg.report_high);
  assign take      = dec.known && in_window;

  always_comb begin
    kept_cel_d  = take ? dec.celsius : kept_cel_q;
    kept_fah_d  = take ? fah : kept_fah_q;
    at_or_above = kept_fah_d >= cfg.trigger_level;
    event_w     = at_or_above == below_q;
    below_d     = !at_or_above;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kept_cel_q <= RST_CEL;
      kept_fah_q <= RST_FAH;
      below_q    <= 1'b1;
    end else if (adv) begin
      kept_cel_q <= kept_cel_d;
      kept_fah_q <= kept_fah_d;
      below_q    <= below_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_cel_q <= kept_cel_d;
      out_fah_q <= kept_fah_d;
      out_acc_q <= take;
      out_unk_q <= !dec.known;
      out_evt_q <= event_w;
      out_ge_q  <= at_or_above;
    end
  end

  assign out_o.valid             = out_valid_q;
  assign out_o.celsius_32nds     = out_cel_q;
  assign out_o.fahrenheit_160ths = out_fah_q;
  assign out_o.reading_accepted  = out_acc_q;
  assign out_o.family_unknown    = out_unk_q;
  assign out_o.crossing_event    = out_evt_q;
  assign out_o.at_or_above       = out_ge_q;

  // stored reading pair stays consistent
  a_kept_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    kept_fah_q == FahW'({{(FahW-CelW){kept_cel_q[CelW-1]}}, kept_cel_q} * 9 + FAH_OFFSET))
    else $error("stored celsius and fahrenheit disagree");

  a_acc_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_acc_q |-> !out_unk_q)
    else $error("reading accepted for unknown family");

  a_adv_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv |=> out_valid_q && below_q == !out_ge_q)
    else $error("result register not loaded or trigger side mismatch");

  a_no_take_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && !take |=> $stable(kept_fah_q) && $stable(kept_cel_q))
    else $error("stored reading changed without acceptance");

endmodule
